### design/bfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfm_pkg;

  // default largest side exponent of the base image
  localparam int unsigned MAX_SIDE_LOG2_DEF = 10;

  localparam int unsigned LOG2_W     = 4;
  localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd10;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned PIX_W      = CH_W * NUM_CH;
  localparam int unsigned SUM_W      = CH_W + 1;
  localparam int unsigned PAIR_W     = SUM_W * NUM_CH;
  localparam int unsigned OUT_USED_W = 2 * POS_W + PIX_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  // register select, taken from paddr bit 2
  localparam logic REG_WIDTH_LOG2  = 1'b0;
  localparam logic REG_HEIGHT_LOG2 = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_MERGE
  } state_e;

  typedef struct packed {
    logic [LOG2_W-1:0] width_log2;
    logic [LOG2_W-1:0] height_log2;
    logic              restart;
  } cfg_t;

endpackage

`default_nettype wire

### design/bfm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bfm_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/bfm_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bfm_regs #(
  parameter int unsigned MAX_SIDE_LOG2 = bfm_pkg::MAX_SIDE_LOG2_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bfm_pkg::APB_AW-1:0]  paddr,
  input  wire logic [bfm_pkg::APB_DW-1:0]  pwdata,
  output logic      [bfm_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output bfm_pkg::cfg_t                    cfg_o
);

  localparam logic [bfm_pkg::LOG2_W-1:0] MAX_LOG2 = bfm_pkg::LOG2_W'(MAX_SIDE_LOG2);

  logic [bfm_pkg::LOG2_W-1:0] width_log2_q, width_log2_d;
  logic [bfm_pkg::LOG2_W-1:0] height_log2_q, height_log2_d;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    width_log2_d  = width_log2_q;
    height_log2_d = height_log2_q;
    if (wr_en) begin
      if (paddr[2] == bfm_pkg::REG_WIDTH_LOG2) begin
        width_log2_d = pwdata[bfm_pkg::LOG2_W-1:0];
      end else begin
        height_log2_d = pwdata[bfm_pkg::LOG2_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= bfm_pkg::LOG2_RESET;
      height_log2_q <= bfm_pkg::LOG2_RESET;
    end else begin
      width_log2_q  <= width_log2_d;
      height_log2_q <= height_log2_d;
    end
  end

  always_comb begin
    if (paddr[2] == bfm_pkg::REG_HEIGHT_LOG2) begin
      prdata = bfm_pkg::APB_DW'(height_log2_q);
    end else begin
      prdata = bfm_pkg::APB_DW'(width_log2_q);
    end
  end

  // exponents above the supported side are clamped
  assign cfg_o.width_log2  = (width_log2_q > MAX_LOG2) ? MAX_LOG2 : width_log2_q;
  assign cfg_o.height_log2 = (height_log2_q > MAX_LOG2) ? MAX_LOG2 : height_log2_q;
  assign cfg_o.restart     = wr_en;

endmodule

`default_nettype wire

### design/bfm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bfm_ctrl #(
  parameter int unsigned MAX_SIDE_LOG2 = bfm_pkg::MAX_SIDE_LOG2_DEF,
  localparam int unsigned AW = MAX_SIDE_LOG2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bfm_pkg::cfg_t                  cfg_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [bfm_pkg::PIX_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [bfm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic      [bfm_pkg::LOG2_W-1:0]     m_axis_tuser,
  output logic                                m_axis_tlast,
  output logic                                ram_we_o,
  output logic                                ram_re_o,
  output logic      [AW-1:0]                  ram_addr_o,
  output logic      [bfm_pkg::PAIR_W-1:0]     ram_wdata_o,
  input  wire logic [bfm_pkg::PAIR_W-1:0]     ram_rdata_i
);

  localparam int unsigned LH_DEPTH = MAX_SIDE_LOG2 + 1;
  localparam int unsigned LH_AW    = $clog2(LH_DEPTH);
  localparam int unsigned PAD_W    = bfm_pkg::OUT_DATA_W - bfm_pkg::OUT_USED_W;
  localparam int unsigned CW       = bfm_pkg::CH_W;
  localparam int unsigned SW       = bfm_pkg::SUM_W;

  bfm_pkg::state_e state_q, state_d;

  logic [AW-1:0]                  col_q, col_d;
  logic [AW-1:0]                  row_q, row_d;
  logic [bfm_pkg::LOG2_W-1:0]     k_q, k_d;
  logic [AW-1:0]                  x_q, x_d;
  logic [AW-1:0]                  y_q, y_d;
  logic [bfm_pkg::PIX_W-1:0]      cur_q, cur_d;
  logic [bfm_pkg::PAIR_W-1:0]     pair_q, pair_d;
  logic [bfm_pkg::PIX_W-1:0]      left_q [LH_DEPTH];

  logic                           out_valid_q, out_valid_d;
  logic [bfm_pkg::LOG2_W-1:0]     out_level_q;
  logic [bfm_pkg::POS_W-1:0]      out_x_q, out_y_q;
  logic [bfm_pkg::PIX_W-1:0]      out_pix_q;
  logic                           out_last_q;

  logic                           s_acc;
  logic                           out_free;
  logic                           out_load;
  logic                           out_last;
  logic                           left_we;
  logic [LH_AW-1:0]               lh_idx;
  logic [bfm_pkg::LOG2_W-1:0]     top;
  logic [AW:0]                    w_full, h_full, idx_full;
  logic [AW-1:0]                  w_mask, h_mask;
  logic [bfm_pkg::PIX_W-1:0]      left_pix;
  logic [bfm_pkg::PAIR_W-1:0]     pair;
  logic [bfm_pkg::PIX_W-1:0]      merged;
  logic [SW:0]                    quad [bfm_pkg::NUM_CH];

  assign s_axis_tready = (state_q == bfm_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign top    = (cfg_i.width_log2 < cfg_i.height_log2) ? cfg_i.width_log2
                                                         : cfg_i.height_log2;
  assign w_full = (AW + 1)'(1) << cfg_i.width_log2;
  assign h_full = (AW + 1)'(1) << cfg_i.height_log2;
  assign w_mask = AW'(w_full - (AW + 1)'(1));
  assign h_mask = AW'(h_full - (AW + 1)'(1));

  // level k of the pair sums starts at w - (w >> k)
  assign idx_full   = w_full - (w_full >> k_q) + {1'b0, x_q >> 1};
  assign ram_addr_o = idx_full[AW-1:0];

  assign lh_idx   = k_q[LH_AW-1:0];
  assign left_pix = left_q[lh_idx];

  always_comb begin
    for (int c = 0; c < bfm_pkg::NUM_CH; c++) begin
      pair[c*SW +: SW] = {1'b0, left_pix[c*CW +: CW]} + {1'b0, cur_q[c*CW +: CW]};
      quad[c]          = {1'b0, ram_rdata_i[c*SW +: SW]} + {1'b0, pair_q[c*SW +: SW]};
      merged[c*CW +: CW] = quad[c][SW:2];
    end
  end

  assign ram_wdata_o = pair;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    k_d         = k_q;
    x_d         = x_q;
    y_d         = y_q;
    cur_d       = cur_q;
    pair_d      = pair_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    left_we     = 1'b0;
    out_load    = 1'b0;
    out_last    = 1'b0;

    case (state_q)
      bfm_pkg::ST_IDLE: begin
        if (s_acc) begin
          cur_d = s_axis_tdata;
          k_d   = '0;
          x_d   = col_q;
          y_d   = row_q;
          if (col_q == w_mask) begin
            col_d = '0;
            row_d = (row_q == h_mask) ? '0 : row_q + AW'(1);
          end else begin
            col_d = col_q + AW'(1);
          end
          state_d = bfm_pkg::ST_LEVEL;
        end
      end
      bfm_pkg::ST_LEVEL: begin
        if (out_free) begin
          out_load = 1'b1;
          if (k_q >= top) begin
            out_last = 1'b1;
            state_d  = bfm_pkg::ST_IDLE;
          end else if (!x_q[0]) begin
            left_we  = 1'b1;
            out_last = 1'b1;
            state_d  = bfm_pkg::ST_IDLE;
          end else if (!y_q[0]) begin
            ram_we_o = 1'b1;
            out_last = 1'b1;
            state_d  = bfm_pkg::ST_IDLE;
          end else begin
            // bottom-right of a 2x2 block: fetch the top pair
            ram_re_o = 1'b1;
            pair_d   = pair;
            state_d  = bfm_pkg::ST_MERGE;
          end
        end
      end
      bfm_pkg::ST_MERGE: begin
        cur_d   = merged;
        k_d     = k_q + bfm_pkg::LOG2_W'(1);
        x_d     = x_q >> 1;
        y_d     = y_q >> 1;
        state_d = bfm_pkg::ST_LEVEL;
      end
      default: begin
        state_d = bfm_pkg::ST_IDLE;
      end
    endcase

    if (cfg_i.restart) begin
      col_d = '0;
      row_d = '0;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfm_pkg::ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    x_q    <= x_d;
    y_q    <= y_d;
    cur_q  <= cur_d;
    pair_q <= pair_d;
    if (left_we) begin
      left_q[lh_idx] <= cur_q;
    end
    if (out_load) begin
      out_level_q <= k_q;
      out_x_q     <= bfm_pkg::POS_W'(x_q);
      out_y_q     <= bfm_pkg::POS_W'(y_q);
      out_pix_q   <= cur_q;
      out_last_q  <= out_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_pix_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_level_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  a_ram_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("pair memory read and written in one cycle");

  a_merge_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfm_pkg::ST_MERGE) |-> $past(ram_re_o))
    else $error("merge without a pending pair read");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("stalled result overwritten");

  a_accept_to_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (state_q == bfm_pkg::ST_LEVEL))
    else $error("accepted pixel not processed");
`endif

endmodule

`default_nettype wire

### design/box_filter_mipmap_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// the level 0 result is registered from ST_LEVEL once the output is free
// a new pixel is taken only in ST_IDLE, after all levels of the last one are loaded
// each extra mip level adds ST_MERGE, for the read-modify of the pair-sum memory
// reset: asynchronous, active low; exponents return to 10, position counters to zero
// memory contents are not cleared, no clearing pass is needed

module box_filter_mipmap_chain #(
  parameter int unsigned MAX_SIDE_LOG2 = bfm_pkg::MAX_SIDE_LOG2_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bfm_pkg::APB_AW-1:0]     paddr,
  input  wire logic [bfm_pkg::APB_DW-1:0]     pwdata,
  output logic      [bfm_pkg::APB_DW-1:0]     prdata,
  output logic                                pready,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // red_in, green_in, blue_in, alpha_in
  input  wire logic [bfm_pkg::PIX_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // pos_x, pos_y, red_out, green_out, blue_out, alpha_out, zero pad
  output logic      [bfm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // level
  output logic      [bfm_pkg::LOG2_W-1:0]     m_axis_tuser,
  // last_of_input
  output logic                                m_axis_tlast
);

  localparam int unsigned AW    = MAX_SIDE_LOG2;
  localparam int unsigned DEPTH = 1 << MAX_SIDE_LOG2;

  bfm_pkg::cfg_t               cfg;
  logic                        ram_we;
  logic                        ram_re;
  logic [AW-1:0]               ram_addr;
  logic [bfm_pkg::PAIR_W-1:0]  ram_wdata;
  logic [bfm_pkg::PAIR_W-1:0]  ram_rdata;

  bfm_regs #(
    .MAX_SIDE_LOG2(MAX_SIDE_LOG2)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  bfm_ctrl #(
    .MAX_SIDE_LOG2(MAX_SIDE_LOG2)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .ram_we_o     (ram_we),
    .ram_re_o     (ram_re),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (ram_rdata)
  );

  // per level, per column pair: channel sums of the even row
  bfm_ram #(
    .WIDTH(bfm_pkg::PAIR_W),
    .DEPTH(DEPTH)
  ) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

endmodule

`default_nettype wire

### bench/mipmap_stream_checker.sv
`timescale 1ns / 1ps

module mipmap_stream_checker
  import bfm_pkg::*;
#(
  parameter int unsigned MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_AW-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  input  wire logic [APB_DW-1:0]     prdata,
  input  wire logic                  pready,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  // red_in, green_in, blue_in, alpha_in
  input  wire logic [PIX_W-1:0]      s_axis_tdata,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // pos_x, pos_y, red_out, green_out, blue_out, alpha_out, zero pad
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  // level
  input  wire logic [LOG2_W-1:0]     m_axis_tuser,
  // last_of_input
  input  wire logic                  m_axis_tlast,
  output int                         fail_count,
  output int                         pending,
  output int                         pixels_seen,
  output int                         results_seen,
  output int                         deepest_level
);

  localparam int unsigned SIDE_MAX = 1 << MAX_SIDE_LOG2;

  typedef struct packed {
    logic [LOG2_W-1:0] level;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [PIX_W-1:0]  rgba;
    logic              last;
  } mip_pixel_t;

  mip_pixel_t mip_expect_q[$];

  logic [LOG2_W-1:0] width_log2_q;
  logic [LOG2_W-1:0] height_log2_q;
  int unsigned       col_count;
  int unsigned       row_count;
  // even-row pair sums per level, and the held even-column pixel per level
  logic [SUM_W-1:0]  pair_sums [SIDE_MAX][NUM_CH];
  logic [CH_W-1:0]   left_hold [MAX_SIDE_LOG2+1][NUM_CH];

  function automatic int unsigned clamp_log2(input logic [LOG2_W-1:0] v);
    return (v > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : int'(v);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    $display("mismatch at %0t: %s is %0h, expected %0h", $time, what, got, want);
  endtask

  // walks one base pixel up the chain and queues every level it completes
  task automatic cascade_pixel(input logic [PIX_W-1:0] pix);
    int unsigned wl, hl, w, h, top, x, y, k, idx;
    logic [CH_W-1:0]  cur  [NUM_CH];
    logic [SUM_W-1:0] pair [NUM_CH];
    mip_pixel_t       r;
    bit               done;
    wl = clamp_log2(width_log2_q);
    hl = clamp_log2(height_log2_q);
    w = 1 << wl;
    h = 1 << hl;
    top = (wl < hl) ? wl : hl;
    x = col_count;
    y = row_count;
    k = 0;
    for (int c = 0; c < NUM_CH; c++) cur[c] = pix[CH_W*c +: CH_W];
    done = 1'b0;
    while (!done) begin
      r.level = k[LOG2_W-1:0];
      r.pos_x = x[POS_W-1:0];
      r.pos_y = y[POS_W-1:0];
      for (int c = 0; c < NUM_CH; c++) r.rgba[CH_W*c +: CH_W] = cur[c];
      if (k >= top) begin
        done = 1'b1;
      end else if (x[0] == 1'b0) begin
        for (int c = 0; c < NUM_CH; c++) left_hold[k][c] = cur[c];
        done = 1'b1;
      end else begin
        for (int c = 0; c < NUM_CH; c++) pair[c] = SUM_W'(left_hold[k][c]) + SUM_W'(cur[c]);
        idx = ((w - (w >> k)) + (x >> 1)) & (SIDE_MAX - 1);
        if (y[0] == 1'b0) begin
          for (int c = 0; c < NUM_CH; c++) pair_sums[idx][c] = pair[c];
          done = 1'b1;
        end else begin
          for (int c = 0; c < NUM_CH; c++)
            cur[c] = CH_W'((10'(pair_sums[idx][c]) + 10'(pair[c])) >> 2);
          x = x >> 1;
          y = y >> 1;
          k++;
        end
      end
      r.last = done;
      mip_expect_q.insert(mip_expect_q.size(), r);
    end
    col_count++;
    if (col_count >= w) begin
      col_count = 0;
      row_count++;
      if (row_count >= h) row_count = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mip_pixel_t  want;
    logic [LOG2_W-1:0] reg_val;
    logic [PIX_W-1:0]  got_rgba;
    if (!rst_ni) begin
      width_log2_q = LOG2_RESET;
      height_log2_q = LOG2_RESET;
      col_count = 0;
      row_count = 0;
      mip_expect_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_WIDTH_LOG2) width_log2_q = pwdata[LOG2_W-1:0];
          else height_log2_q = pwdata[LOG2_W-1:0];
          col_count = 0;
          row_count = 0;
        end else begin
          reg_val = (paddr[2] == REG_WIDTH_LOG2) ? width_log2_q : height_log2_q;
          if (prdata !== {{(APB_DW-LOG2_W){1'b0}}, reg_val})
            report_mismatch("register read", prdata, reg_val);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cascade_pixel(s_axis_tdata);
        pixels_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (int'(m_axis_tuser) > deepest_level) deepest_level = m_axis_tuser;
        if (mip_expect_q.size() == 0) begin
          report_mismatch("result with nothing pending, level", m_axis_tuser, 0);
        end else begin
          want = mip_expect_q.pop_front();
          got_rgba = m_axis_tdata[2*POS_W +: PIX_W];
          if (m_axis_tuser !== want.level) report_mismatch("level", m_axis_tuser, want.level);
          if (m_axis_tdata[POS_W-1:0] !== want.pos_x)
            report_mismatch("pos_x", m_axis_tdata[POS_W-1:0], want.pos_x);
          if (m_axis_tdata[2*POS_W-1:POS_W] !== want.pos_y)
            report_mismatch("pos_y", m_axis_tdata[2*POS_W-1:POS_W], want.pos_y);
          if (got_rgba[7:0] !== want.rgba[7:0])
            report_mismatch("red", got_rgba[7:0], want.rgba[7:0]);
          if (got_rgba[15:8] !== want.rgba[15:8])
            report_mismatch("green", got_rgba[15:8], want.rgba[15:8]);
          if (got_rgba[23:16] !== want.rgba[23:16])
            report_mismatch("blue", got_rgba[23:16], want.rgba[23:16]);
          if (got_rgba[31:24] !== want.rgba[31:24])
            report_mismatch("alpha", got_rgba[31:24], want.rgba[31:24]);
          if (m_axis_tlast !== want.last)
            report_mismatch("last_of_input", m_axis_tlast, want.last);
        end
      end
      pending <= mip_expect_q.size();
    end
  end

endmodule

### bench/tb_box_filter_mipmap_chain.sv
`timescale 1ns / 1ps

module tb_box_filter_mipmap_chain;
  import bfm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASE_PIXELS = 36;
  localparam logic [APB_AW-1:0] ADDR_WIDTH_LOG2  = {REG_WIDTH_LOG2, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_HEIGHT_LOG2 = {REG_HEIGHT_LOG2, 2'b00};
  localparam logic APB_WRITE = 1'b1;
  localparam logic APB_READ  = 1'b0;

  typedef enum int {
    FLOW_FREE,
    FLOW_SRC_SLOW,
    FLOW_SINK_SLOW,
    FLOW_BOTH_SLOW
  } flow_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [LOG2_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  flow_e flow = FLOW_FREE;
  int    quiet_cycles = 0;
  int    settings_used = 0;
  int    fail_count, pending, pixels_seen, results_seen, deepest_level;

  box_filter_mipmap_chain uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mipmap_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .pixels_seen   (pixels_seen),
    .results_seen  (results_seen),
    .deepest_level (deepest_level)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    case (flow)
      FLOW_SINK_SLOW: m_axis_tready <= ($urandom_range(99) >= 87);
      FLOW_BOTH_SLOW: m_axis_tready <= ($urandom_range(99) >= 21);
      default:        m_axis_tready <= 1'b1;
    endcase
  end

  // counts cycles with no request taken on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_size(input int unsigned wl, input int unsigned hl);
    apb_access(APB_WRITE, ADDR_WIDTH_LOG2, APB_DW'(wl));
    apb_access(APB_WRITE, ADDR_HEIGHT_LOG2, APB_DW'(hl));
    apb_access(APB_READ, ADDR_WIDTH_LOG2, '0);
    apb_access(APB_READ, ADDR_HEIGHT_LOG2, '0);
    settings_used++;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned idle_pct;
    idle_pct = (flow == FLOW_SRC_SLOW) ? 87 : (flow == FLOW_BOTH_SLOW) ? 21 : 0;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // every pixel yields results, so an empty queue means the block is idle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] pix;
    for (int c = 0; c < NUM_CH; c++) begin
      case ($urandom_range(7))
        0:       pix[CH_W*c +: CH_W] = '0;
        1:       pix[CH_W*c +: CH_W] = '1;
        default: pix[CH_W*c +: CH_W] = CH_W'($urandom_range(255));
      endcase
    end
    return pix;
  endfunction

  initial begin
    int unsigned wl, hl, n, swap, sent;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size, then tiny images with channel extremes and rounding down
    send_pixel('0);
    send_pixel('1);
    drain();
    set_size(1, 1);
    repeat (4) send_pixel('1);
    send_pixel(32'hFF00_0301);
    send_pixel(32'h00FF_0200);
    send_pixel(32'hFE00_0100);
    send_pixel(32'h0001_0000);
    // wraps into the next image
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    drain();
    // a single register write restarts the image mid-way
    apb_access(APB_WRITE, ADDR_HEIGHT_LOG2, APB_DW'(1));
    repeat (4) send_pixel(random_pixel());
    drain();
    set_size(0, 0);
    repeat (2) send_pixel(random_pixel());
    drain();
    // exponents beyond the maximum side
    set_size(15, 0);
    repeat (3) send_pixel(random_pixel());
    drain();
    set_size(0, 12);
    repeat (3) send_pixel(random_pixel());
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      flow = flow_e'(ph);
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        if ($urandom_range(5) == 0) begin
          wl = $urandom_range(10, 15);
          hl = $urandom_range(0, 1);
          n = $urandom_range(6, 24);
        end else begin
          wl = $urandom_range(0, 6);
          hl = $urandom_range(0, 6 - wl);
          n = 1 << (wl + hl);
          if ($urandom_range(3) == 0) n = $urandom_range(1, n);
          else n += $urandom_range(0, 3);
        end
        if (n > PHASE_PIXELS - sent) n = PHASE_PIXELS - sent;
        swap = $urandom_range(1);
        if (swap != 0) set_size(hl, wl);
        else set_size(wl, hl);
        repeat (n) send_pixel(random_pixel());
        drain();
        sent += n;
      end
    end

    flow = FLOW_FREE;
    repeat (32) @(posedge clk_i);
    $display("run covered %0d pixels over %0d image sizes and four flow-control mixes",
             pixels_seen, settings_used);
    $display("%0d results compared, deepest mip level reached %0d", results_seen,
             deepest_level);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/bfm_pkg.sv
design/bfm_ram.sv
design/bfm_regs.sv
design/bfm_ctrl.sv
design/box_filter_mipmap_chain.sv
bench/mipmap_stream_checker.sv
bench/tb_box_filter_mipmap_chain.sv
